// ===== rtl/opd_pkg.sv =====
package opd_pkg;

  // Fixed page header layout
  localparam int          HEADER_BYTES = 27;
  localparam logic [31:0] OGGS_WORD    = 32'h5367674F;
  localparam logic [7:0]  SEQ_FIRST    = 8'd18;
  localparam logic [7:0]  SEQ_LAST     = 8'd21;

  // Result kinds
  localparam logic [2:0] KIND_PAYLOAD     = 3'd0;
  localparam logic [2:0] KIND_HEADER_DONE = 3'd1;
  localparam logic [2:0] KIND_BAD_MAGIC   = 3'd2;
  localparam logic [2:0] KIND_NO_SEGMENTS = 3'd3;
  localparam logic [2:0] KIND_TRUNCATED   = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } src_beat_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  segment_number;
    logic        segment_last;
    logic        page_last;
    logic [15:0] page_length;
    logic [31:0] page_sequence;
  } res_beat_t;

endpackage

// ===== rtl/opd_ram.sv =====
module opd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 255
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; a same-cycle write to the read address passes through
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ogg_page_deframer_unit.sv =====
// Ogg page deframer.
// Input channel (src_valid / src_stall / src_beat): one stream byte per beat,
// or a stream-end mark. Result channel (res_valid / res_stall / res_beat): at
// most one result per input beat: a payload byte tagged with its segment
// number and segment-end / page-end marks, a header-done beat carrying the
// page length and sequence number, or an error (bad magic, no or too many
// segments, stream truncated inside a page). After an error the block waits
// for a new page header. Zero-length segments give no beat.
// A result appears on res_valid in the cycle after its input beat is taken.
// One input beat per cycle is taken, in every phase, while src_stall is low.
// Nonzero segment lengths are packed into a table RAM as the segment table
// streams in; payload walks that list through a one-entry read-ahead, so a
// string of empty segments never holds up the payload.
// src_stall is high only while a result is held and res_stall is high; a
// stalled result stays unchanged. Synchronous reset (rst) returns the block
// to waiting for a page header with no result pending; the RAM needs no
// clearing, since every entry is written before it is read.
module ogg_page_deframer_unit
  import opd_pkg::*;
#(
  parameter int MAX_SEGMENTS = 255
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  output logic      src_stall,
  input  src_beat_t src_beat,
  output logic      res_valid,
  input  logic      res_stall,
  output res_beat_t res_beat
);

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_TABLE   = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  byte_counter, byte_counter_next;
  logic        magic_ok, magic_ok_next;
  logic [31:0] sequence_word, sequence_word_next;
  logic [7:0]  segment_total, segment_total_next;
  logic [15:0] length_sum, length_sum_next;
  logic [7:0]  cur_len, cur_len_next;
  logic [7:0]  cur_idx, cur_idx_next;
  logic [AW-1:0] wr_count, wr_count_next;
  logic [AW-1:0] rd_ptr, rd_ptr_next;

  logic        accept;
  logic        emit;
  res_beat_t   beat_next;
  logic        header_like;
  logic        magic_match;
  logic [1:0]  seq_lane;
  logic [15:0] sum_add;
  logic        table_more;

  logic          ram_we;
  logic [15:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;
  logic          advance;

  assign src_stall = res_valid && res_stall;
  assign accept    = src_valid && !src_stall;

  assign header_like = (phase != PH_TABLE) && (phase != PH_PAYLOAD);
  assign magic_match = (src_beat.in_byte == OGGS_WORD[{byte_counter[1:0], 3'b000} +: 8]);
  assign seq_lane    = 2'(byte_counter - SEQ_FIRST);
  assign sum_add     = length_sum + {8'h00, src_beat.in_byte};
  assign table_more  = ({1'b0, byte_counter} + 9'd1) < {1'b0, segment_total};

  assign ram_wdata = {byte_counter, src_beat.in_byte};
  assign ram_raddr = advance ? (rd_ptr + AW'(1)) : rd_ptr;

  // Next state and result for the beat being taken
  always_comb begin
    phase_next         = phase;
    byte_counter_next  = byte_counter;
    magic_ok_next      = magic_ok;
    sequence_word_next = sequence_word;
    segment_total_next = segment_total;
    length_sum_next    = length_sum;
    cur_len_next       = cur_len;
    cur_idx_next       = cur_idx;
    wr_count_next      = wr_count;
    rd_ptr_next        = rd_ptr;
    ram_we             = 1'b0;
    advance            = 1'b0;
    emit               = 1'b0;
    beat_next          = '0;

    if (accept) begin
      if (src_beat.stream_end) begin
        // Report a page cut short; stay silent between pages
        if (!(header_like && (byte_counter == 8'd0))) begin
          phase_next            = PH_HEADER;
          byte_counter_next     = 8'd0;
          emit                  = 1'b1;
          beat_next.result_kind = KIND_TRUNCATED;
        end
      end else begin
        case (phase)
          PH_TABLE: begin
            // Pack nonzero lengths with their segment index
            length_sum_next = sum_add;
            if (src_beat.in_byte != 8'd0) begin
              ram_we        = 1'b1;
              wr_count_next = wr_count + AW'(1);
              if (wr_count == '0) begin
                cur_len_next = src_beat.in_byte;
                cur_idx_next = byte_counter;
              end
            end
            if (table_more) begin
              byte_counter_next = byte_counter + 8'd1;
            end else begin
              byte_counter_next       = 8'd0;
              emit                    = 1'b1;
              beat_next.result_kind   = KIND_HEADER_DONE;
              beat_next.page_length   = sum_add;
              beat_next.page_sequence = sequence_word;
              phase_next = (sum_add == 16'd0) ? PH_HEADER : PH_PAYLOAD;
            end
          end

          PH_PAYLOAD: begin
            // Tag and pass the byte; at a segment's end step to the next packed segment
            emit                     = 1'b1;
            beat_next.result_kind    = KIND_PAYLOAD;
            beat_next.payload_byte   = src_beat.in_byte;
            beat_next.segment_number = cur_idx;
            beat_next.segment_last   = (cur_len == 8'd1);
            beat_next.page_last      = (length_sum == 16'd1);
            length_sum_next          = length_sum - 16'd1;
            cur_len_next             = cur_len - 8'd1;
            if (length_sum == 16'd1) begin
              phase_next        = PH_HEADER;
              byte_counter_next = 8'd0;
            end else if (cur_len == 8'd1) begin
              advance      = 1'b1;
              cur_len_next = ram_rdata[7:0];
              cur_idx_next = ram_rdata[15:8];
              rd_ptr_next  = rd_ptr + AW'(1);
            end
          end

          default: begin
            // Header bytes: check magic, capture sequence, judge segment count
            phase_next = PH_HEADER;
            if (byte_counter == 8'd0) begin
              magic_ok_next      = magic_match;
              sequence_word_next = '0;
            end else if (byte_counter < 8'd4) begin
              magic_ok_next = magic_ok && magic_match;
            end
            if ((byte_counter >= SEQ_FIRST) && (byte_counter <= SEQ_LAST)) begin
              sequence_word_next[{seq_lane, 3'b000} +: 8] = src_beat.in_byte;
            end
            if (byte_counter != 8'(HEADER_BYTES - 1)) begin
              byte_counter_next = byte_counter + 8'd1;
            end else begin
              byte_counter_next = 8'd0;
              if (!magic_ok) begin
                emit                  = 1'b1;
                beat_next.result_kind = KIND_BAD_MAGIC;
              end else if ((src_beat.in_byte == 8'd0) ||
                           (int'(src_beat.in_byte) > MAX_SEGMENTS)) begin
                emit                  = 1'b1;
                beat_next.result_kind = KIND_NO_SEGMENTS;
              end else begin
                segment_total_next = src_beat.in_byte;
                length_sum_next    = 16'd0;
                wr_count_next      = '0;
                rd_ptr_next        = AW'(1);
                phase_next         = PH_TABLE;
              end
            end
          end
        endcase
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      byte_counter <= 8'd0;
      res_valid    <= 1'b0;
    end else begin
      phase        <= phase_next;
      byte_counter <= byte_counter_next;
      if (accept) begin
        res_valid <= emit;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    magic_ok      <= magic_ok_next;
    sequence_word <= sequence_word_next;
    segment_total <= segment_total_next;
    length_sum    <= length_sum_next;
    cur_len       <= cur_len_next;
    cur_idx       <= cur_idx_next;
    wr_count      <= wr_count_next;
    rd_ptr        <= rd_ptr_next;
    if (accept && emit) begin
      res_beat <= beat_next;
    end
  end

  // Packed table of nonzero segments: {segment index, length}
  opd_ram #(
    .WIDTH (16),
    .DEPTH (MAX_SEGMENTS)
  ) u_seg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_count),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
